FILE: rtl/jcd_pkg.sv
// Shared types, constants and helpers for the JPEG coefficient decoder.
package jcd_pkg;

	localparam int DEF_COMPONENTS = 3;

	localparam logic       FUNC_DC     = 1'b0;
	localparam logic       FUNC_AC     = 1'b1;
	localparam logic [7:0] SYM_EOB     = 8'h00;
	localparam logic [7:0] SYM_ZRL     = 8'hF0;
	localparam logic [7:0] DC_SIZE_MAX = 8'd15;
	localparam logic [6:0] BLOCK_LEN   = 7'd64;
	localparam logic [6:0] ZRL_LEN     = 7'd16;
	localparam logic [5:0] LAST_IDX    = 6'd63;

	typedef struct packed {
		logic        func;
		logic [1:0]  component;
		logic [7:0]  symbol;
		logic [14:0] extra_bits;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] coefficient;
		logic [5:0]         coef_index;
		logic               last;
		logic               block_done;
		logic               error;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic emit_zero;
		logic emit_val;
	} ctrl_cmd_t;

	typedef struct packed {
		logic zeros_pending;
		logic last_zero;
		logic out_free;
	} dp_status_t;

	// JPEG magnitude category extension: low size bits, negative when the top bit is clear.
	function automatic logic signed [15:0] extend_value(input logic [3:0] size,
			input logic [14:0] raw);
		logic [15:0] full;
		logic [15:0] bits;
		logic [15:0] half;
		full = (16'd1 << size) - 16'd1;
		bits = {1'b0, raw} & full;
		half = 16'd1 << (size - 4'd1);
		if (size == 4'd0) begin
			extend_value = 16'sd0;
		end else if (bits < half) begin
			extend_value = signed'(bits - full);
		end else begin
			extend_value = signed'(bits);
		end
	endfunction

endpackage

FILE: rtl/jcd_if.sv
// Valid/ready stream interfaces for symbol requests and coefficient results.
interface jcd_sym_if;
	import jcd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface jcd_coef_if;
	import jcd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/jcd_ctrl.sv
// Sequencer: takes a request, then steps the datapath through its results.
module jcd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jcd_pkg::dp_status_t status,
	input  logic               has_val,
	output jcd_pkg::ctrl_cmd_t  cmd
);
	import jcd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (status.out_free) begin
					if (status.zeros_pending) begin
						if (status.last_zero) state_d = ST_IDLE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.emit_zero = 1'b0;
		cmd.emit_val  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.emit_zero = status.out_free && status.zeros_pending;
				// with no zeros left, the job always ends in its value result
				cmd.emit_val  = status.out_free && !status.zeros_pending && has_val;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/jcd_datapath.sv
// Symbol decode, DC predictors, block position, zero-run counter and result register.
module jcd_datapath #(
	parameter int COMPONENTS = jcd_pkg::DEF_COMPONENTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  jcd_pkg::in_item_t   in_data,
	input  jcd_pkg::ctrl_cmd_t  cmd,
	output jcd_pkg::dp_status_t status,
	output logic                has_val,
	output logic                out_valid,
	output jcd_pkg::out_item_t  out_data,
	input  logic                out_ready
);
	import jcd_pkg::*;

	localparam int CompW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

	logic [15:0] pred_q [COMPONENTS];
	logic [5:0]  pos_q;
	logic [5:0]  zeros_q;
	logic        has_val_q;
	logic signed [15:0] val_q;
	logic        val_err_q;
	logic        val_at_pos_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [CompW-1:0]   comp_idx;
	logic               comp_ok;
	logic [3:0]         run;
	logic [3:0]         size;
	logic signed [15:0] ext;
	logic [15:0]        dc_new;
	logic [6:0]         pos_run;
	logic [6:0]         rem;
	logic [6:0]         zrl_n;
	logic               dc_ok;
	logic               ac_open;
	logic               ac_err;
	logic               is_eob;
	logic               is_zrl;
	logic [5:0]         pos_inc;

	assign comp_idx = in_data.component[CompW-1:0];
	assign comp_ok  = int'(in_data.component) < COMPONENTS;
	assign run      = in_data.symbol[7:4];
	assign size     = in_data.symbol[3:0];
	assign ext      = extend_value(size, in_data.extra_bits);
	assign dc_new   = pred_q[comp_idx] + ext;
	assign pos_run  = {1'b0, pos_q} + {3'b000, run};
	assign rem      = BLOCK_LEN - {1'b0, pos_q};
	assign zrl_n    = (rem > ZRL_LEN) ? ZRL_LEN : rem;
	assign dc_ok    = (in_data.symbol <= DC_SIZE_MAX) && comp_ok;
	assign ac_open  = pos_q != 6'd0;
	assign is_eob   = in_data.symbol == SYM_EOB;
	assign is_zrl   = in_data.symbol == SYM_ZRL;
	assign ac_err   = !ac_open ||
		(!is_eob && !is_zrl && (size == 4'd0 || pos_run > {1'b0, LAST_IDX}));
	// index 63 closes the block and drops back to waiting for DC
	assign pos_inc  = (pos_q == LAST_IDX) ? 6'd0 : pos_q + 6'd1;

	assign status.zeros_pending = zeros_q != 6'd0;
	assign status.last_zero     = (zeros_q == 6'd1) && !has_val_q;
	assign status.out_free      = !out_valid_q || out_ready;
	assign has_val              = has_val_q;
	assign out_valid            = out_valid_q;
	assign out_data             = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < COMPONENTS; c++) pred_q[c] <= 16'd0;
			pos_q <= 6'd0;
		end else if (cmd.load) begin
			if (in_data.func == FUNC_DC) begin
				if (dc_ok) begin
					pred_q[comp_idx] <= dc_new;
					pos_q <= 6'd1;
				end else begin
					pos_q <= 6'd0;
				end
			end else if (ac_err) begin
				pos_q <= 6'd0;
			end
		end else if (cmd.emit_zero || (cmd.emit_val && val_at_pos_q)) begin
			pos_q <= pos_inc;
		end
	end

	// job registers: loaded on request, drained by the emit commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zeros_q   <= 6'd0;
			has_val_q <= 1'b0;
		end else if (cmd.load) begin
			if (in_data.func == FUNC_DC || ac_err) begin
				zeros_q   <= 6'd0;
				has_val_q <= 1'b1;
			end else if (is_eob) begin
				zeros_q   <= rem[5:0];
				has_val_q <= 1'b0;
			end else if (is_zrl) begin
				zeros_q   <= zrl_n[5:0];
				has_val_q <= 1'b0;
			end else begin
				zeros_q   <= {2'b00, run};
				has_val_q <= 1'b1;
			end
		end else if (cmd.emit_zero) begin
			zeros_q <= zeros_q - 6'd1;
		end else if (cmd.emit_val) begin
			has_val_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (in_data.func == FUNC_DC && dc_ok) begin
				val_q        <= signed'(dc_new);
				val_err_q    <= 1'b0;
				val_at_pos_q <= 1'b0;
			end else if (in_data.func == FUNC_DC || ac_err) begin
				val_q        <= 16'sd0;
				val_err_q    <= 1'b1;
				val_at_pos_q <= 1'b0;
			end else begin
				val_q        <= ext;
				val_err_q    <= 1'b0;
				val_at_pos_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_zero || cmd.emit_val) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_zero) begin
			out_q.coefficient <= 16'sd0;
			out_q.coef_index  <= pos_q;
			out_q.last        <= status.last_zero;
			out_q.block_done  <= pos_q == LAST_IDX;
			out_q.error       <= 1'b0;
		end else if (cmd.emit_val) begin
			out_q.coefficient <= val_q;
			out_q.coef_index  <= val_at_pos_q ? pos_q : 6'd0;
			out_q.last        <= 1'b1;
			out_q.block_done  <= val_at_pos_q && (pos_q == LAST_IDX);
			out_q.error       <= val_err_q;
		end
	end

endmodule

FILE: rtl/jpeg_coefficient_decoder.sv
// A request is held in the job registers and sequencer state; its results leave through the result register on coef.
// Each request yields N results (1 to 63), one result per cycle out of the zero-run counter
//   while coef is not stalled; no new request is taken until its last result is issued.
// sym.ready is high whenever the sequencer is idle, even with a result still in the register.
// Reset (arst_n low, asynchronous) clears the DC predictors, block position,
//   sequencer and result valid; no sweep is needed afterward.
module jpeg_coefficient_decoder #(
	parameter int COMPONENTS = jcd_pkg::DEF_COMPONENTS
) (
	input logic         clk,
	input logic         arst_n,
	jcd_sym_if.sink     sym,
	jcd_coef_if.source  coef
);
	import jcd_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       has_val;

	jcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sym.valid),
		.in_ready (sym.ready),
		.status   (status),
		.has_val  (has_val),
		.cmd      (cmd)
	);

	jcd_datapath #(
		.COMPONENTS (COMPONENTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (sym.data),
		.cmd       (cmd),
		.status    (status),
		.has_val   (has_val),
		.out_valid (coef.valid),
		.out_data  (coef.data),
		.out_ready (coef.ready)
	);

endmodule

FILE: rtl/jcd_checker.sv
// Port-level assertions for the JPEG coefficient decoder, bound to the top level.
module jcd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sym_valid,
	input logic               sym_ready,
	input logic               coef_valid,
	input logic               coef_ready,
	input jcd_pkg::out_item_t coef_data
);
	import jcd_pkg::*;

	// an error result stands alone: zero value, index 0, final, never completes a block
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && coef_data.error |->
			coef_data.last && !coef_data.block_done &&
			coef_data.coefficient == 16'sd0 && coef_data.coef_index == 6'd0)
		else $error("error result malformed");

	a_block_done: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && coef_data.block_done |->
			coef_data.last && coef_data.coef_index == LAST_IDX)
		else $error("block_done off the last index or not final");

	// while a request still owes results, no new request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && !coef_data.last |-> !sym_ready)
		else $error("request taken while results pending");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym_ready |=> !sym_ready)
		else $error("back-to-back request accept");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && !coef_ready |=> coef_valid && $stable(coef_data))
		else $error("stalled result changed");

endmodule

bind jpeg_coefficient_decoder jcd_checker u_jcd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.sym_valid  (sym.valid),
	.sym_ready  (sym.ready),
	.coef_valid (coef.valid),
	.coef_ready (coef.ready),
	.coef_data  (coef.data)
);

FILE: verif/testbench.sv
// Self-checking bench for jpeg_coefficient_decoder: symbol stream in, coefficients predicted.
module testbench;
	import jcd_pkg::*;

	localparam int NCOMP      = DEF_COMPONENTS;
	localparam int RAND_ITEMS = 120;

	// Holds the decoder's predicted state and the coefficients still owed by the block.
	class coef_ledger;
		int          n_comp;
		logic [15:0] dc_pred [4];
		int unsigned blk_pos;
		out_item_t   due_coefs[$];
		int unsigned fails;

		function new(int comps);
			n_comp = comps;
			foreach (dc_pred[i]) dc_pred[i] = '0;
			blk_pos = 0;
			fails = 0;
		endfunction

		function logic [15:0] extend_bits(logic [3:0] size, logic [14:0] raw);
			int mask;
			int v;
			if (size == 4'd0) return '0;
			mask = (1 << size) - 1;
			v = int'(raw) & mask;
			// top bit clear means a negative magnitude
			if (v < (1 << (size - 4'd1))) return 16'(v - mask);
			return 16'(v);
		endfunction

		function void push_coef(logic [15:0] value, int unsigned idx, bit is_last, bit err);
			out_item_t c;
			c.coefficient = value;
			c.coef_index  = idx[5:0];
			c.last        = is_last;
			c.block_done  = !err && idx == int'(LAST_IDX);
			c.error       = err;
			due_coefs.push_back(c);
		endfunction

		function void push_zeros(int unsigned n, bit closes);
			for (int unsigned i = 0; i < n; i++) begin
				push_coef('0, blk_pos, closes && i == n - 1, 1'b0);
				blk_pos++;
			end
		endfunction

		function void flag_error();
			blk_pos = 0;
			push_coef('0, 0, 1'b1, 1'b1);
		endfunction

		function void note_request(in_item_t r);
			int unsigned run;
			int unsigned n;
			logic [3:0]  sz;
			if (r.func == FUNC_DC) begin
				if (r.symbol > DC_SIZE_MAX || int'(r.component) >= n_comp) begin
					flag_error();
					return;
				end
				// predictor wraps modulo 2^16
				dc_pred[r.component] = dc_pred[r.component] +
					extend_bits(r.symbol[3:0], r.extra_bits);
				blk_pos = 1;
				push_coef(dc_pred[r.component], 0, 1'b1, 1'b0);
				return;
			end
			if (blk_pos == 0 || blk_pos >= int'(BLOCK_LEN)) begin
				flag_error();
				return;
			end
			run = r.symbol[7:4];
			sz  = r.symbol[3:0];
			if (r.symbol == SYM_EOB) begin
				push_zeros(int'(BLOCK_LEN) - blk_pos, 1'b1);
			end else if (r.symbol == SYM_ZRL) begin
				n = int'(BLOCK_LEN) - blk_pos;
				if (n > int'(ZRL_LEN)) n = int'(ZRL_LEN);
				push_zeros(n, 1'b1);
			end else if (sz == 4'd0 || blk_pos + run > int'(LAST_IDX)) begin
				flag_error();
				return;
			end else begin
				push_zeros(run, 1'b0);
				push_coef(extend_bits(sz, r.extra_bits), blk_pos, 1'b1, 1'b0);
				blk_pos++;
			end
			if (blk_pos >= int'(BLOCK_LEN)) blk_pos = 0;
		endfunction

		function void report_mismatch(string what, logic signed [31:0] got,
				logic signed [31:0] want);
			fails++;
			$display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (due_coefs.size() == 0) begin
				report_mismatch("result with nothing pending", got.coef_index, -1);
				return;
			end
			want = due_coefs.pop_front();
			if (got.coefficient !== want.coefficient)
				report_mismatch("coefficient", got.coefficient, want.coefficient);
			if (got.coef_index !== want.coef_index)
				report_mismatch("coef_index", got.coef_index, want.coef_index);
			if (got.last !== want.last)
				report_mismatch("last", got.last, want.last);
			if (got.block_done !== want.block_done)
				report_mismatch("block_done", got.block_done, want.block_done);
			if (got.error !== want.error)
				report_mismatch("error", got.error, want.error);
		endfunction

		function int outstanding();
			return due_coefs.size();
		endfunction

		function void drain_check();
			if (due_coefs.size() != 0)
				report_mismatch("results never produced", 0, due_coefs.size());
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	int   sent = 0;
	coef_ledger ledger;

	jcd_sym_if  sym_ch ();
	jcd_coef_if coef_ch ();

	jpeg_coefficient_decoder #(.COMPONENTS(NCOMP)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sym    (sym_ch),
		.coef   (coef_ch)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_sym(input logic f, input logic [1:0] c, input logic [7:0] s,
			input logic [14:0] x);
		in_item_t req;
		int gap;
		req.func       = f;
		req.component  = c;
		req.symbol     = s;
		req.extra_bits = x;
		gap = pick_gap();
		if (gap > 0) begin
			sym_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sym_ch.valid <= 1'b1;
		sym_ch.data  <= req;
		@(posedge clk);
		while (!sym_ch.ready) @(posedge clk);
		sent++;
	endtask

	// A DC-opened block of random AC content, sometimes cut short or broken on purpose.
	task automatic random_block();
		int unsigned at;
		int unsigned room;
		int unsigned run;
		int r;
		send_sym(FUNC_DC, 2'($urandom_range(0, NCOMP - 1)), 8'($urandom_range(0, 15)),
			15'($urandom));
		at = 1;
		while (at < int'(BLOCK_LEN)) begin
			r = $urandom_range(0, 99);
			room = int'(LAST_IDX) - at;
			if (r < 18) begin
				send_sym(FUNC_AC, 2'($urandom), SYM_EOB, 15'($urandom));
				at = int'(BLOCK_LEN);
			end else if (r < 28) begin
				send_sym(FUNC_AC, 2'($urandom), SYM_ZRL, 15'($urandom));
				at += (room + 1 < int'(ZRL_LEN)) ? room + 1 : int'(ZRL_LEN);
			end else if (r < 31) begin
				// size zero with a run that is not ZRL
				send_sym(FUNC_AC, 2'($urandom), {4'($urandom_range(1, 14)), 4'h0},
					15'($urandom));
				return;
			end else if (r < 34) begin
				// overrun past the block end when possible, otherwise abandon via next DC
				if (room < 15)
					send_sym(FUNC_AC, 2'($urandom),
						{4'($urandom_range(room + 1, 15)), 4'($urandom_range(1, 15))},
						15'($urandom));
				return;
			end else begin
				run = $urandom_range(0, room < 15 ? room : 15);
				send_sym(FUNC_AC, 2'($urandom), {4'(run), 4'($urandom_range(1, 15))},
					15'($urandom));
				at += run + 1;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (sym_ch.valid && sym_ch.ready) ledger.note_request(sym_ch.data);
			if (coef_ch.valid && coef_ch.ready) ledger.check_result(coef_ch.data);
		end
	end

	initial begin
		int stall;
		coef_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				coef_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			coef_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		ledger = new(NCOMP);
		arst_n       <= 1'b0;
		sym_ch.valid <= 1'b0;
		sym_ch.data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sym(FUNC_AC, 2'd0, 8'h11, 15'h0001);	// AC with no block open
		send_sym(FUNC_DC, 2'd0, 8'd0, 15'h7FFF);
		send_sym(FUNC_AC, 2'd0, SYM_EOB, 15'h0000);	// longest zero run
		send_sym(FUNC_AC, 2'd3, 8'h01, 15'h7FFF);	// after the block closed
		send_sym(FUNC_DC, 2'd0, 8'd15, 15'h7FFF);
		send_sym(FUNC_DC, 2'd0, 8'd15, 15'h7FFF);	// open block abandoned, predictor wraps
		send_sym(FUNC_DC, 2'd1, 8'd15, 15'h0000);
		send_sym(FUNC_DC, 2'd3, 8'd1, 15'h0001);	// component out of range
		send_sym(FUNC_DC, 2'd2, 8'h10, 15'h0001);	// DC size too big
		send_sym(FUNC_DC, 2'd2, 8'hFF, 15'h7FFF);
		send_sym(FUNC_DC, 2'd2, 8'd1, 15'h0000);
		send_sym(FUNC_AC, 2'd2, 8'h01, 15'h0001);
		send_sym(FUNC_AC, 2'd2, 8'h0F, 15'h0000);
		send_sym(FUNC_AC, 2'd2, 8'hFA, 15'h03FF);
		send_sym(FUNC_AC, 2'd2, 8'h30, 15'h0005);	// size zero, not EOB or ZRL
		send_sym(FUNC_DC, 2'd1, 8'd4, 15'h0005);
		repeat (3) send_sym(FUNC_AC, 2'd1, SYM_ZRL, 15'h2AAA);
		send_sym(FUNC_AC, 2'd1, 8'hF1, 15'h0001);	// run past index 63
		send_sym(FUNC_DC, 2'd0, 8'd2, 15'h0003);
		repeat (3) send_sym(FUNC_AC, 2'd0, SYM_ZRL, 15'h5555);
		send_sym(FUNC_AC, 2'd0, 8'hE1, 15'h0001);	// value lands exactly on index 63
		send_sym(FUNC_DC, 2'd1, 8'd0, 15'h0000);
		repeat (4) send_sym(FUNC_AC, 2'd1, SYM_ZRL, 15'h0000);	// last ZRL truncated

		while (sent < RAND_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 12)
				send_sym(1'($urandom), 2'($urandom), 8'($urandom), 15'($urandom));
			else
				random_block();
		end
		calm = 1'b0;
		sym_ch.valid <= 1'b0;

		while (ledger.outstanding() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		ledger.drain_check();
		if (ledger.fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("FAILURE");
		$finish;
	end

endmodule
